>>> rtl/nid_pkg.sv
// shared constants for the newton square root and distance block
`default_nettype none

package nid_pkg;

  // field widths of the item channels
  localparam int RADICAND_W  = 31;
  localparam int POINT_W     = 21;
  localparam int ROOT_W      = 23;
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 24;

  // starting guesses and the magnitude bounds that pick them
  localparam int GUESS_SMALL = 50;
  localparam int GUESS_MID   = 500;
  localparam int GUESS_LARGE = 5000;
  localparam int BOUND_SMALL = 6824;
  localparam int BOUND_MID   = 682400;

  // successive guesses closer than this end the iteration
  localparam int CONVERGE_GAP = 2;

  // item kinds
  localparam logic KIND_ROOT     = 1'b0;
  localparam logic KIND_DISTANCE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/newton_isqrt_distance.sv
// newton-raphson integer square root and scaled 3d point distance
// An item asks either for the integer square root of a radicand (tuser 0) or for
// the distance between two 3d points (tuser 1). For a distance the three axis
// differences are floor-shifted right by LENGTH_SHIFT, squared one after another
// on a single multiplier and summed; the root of the sum is shifted back left.
// The root runs Newton steps g' = (g + x/g)/2 from a seed of 50, 500 or 5000,
// stopping when two guesses differ by less than 2, or after MAX_STEPS steps with
// the capped flag set. Each step divides on one restoring radix-2 divider that
// yields one quotient bit a cycle; XW, the operand width, is 34 bits at
// LENGTH_SHIFT 6. The input is ready only while no item is in progress; a
// finished result waits in the output register and the next item may be taken
// while it waits. A result that finds the output register still full holds the
// block until that register is emptied.
`default_nettype none

module newton_isqrt_distance #(
  parameter int LENGTH_SHIFT = 6,
  parameter int MAX_STEPS    = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // radicand, from_x, from_y, from_z, to_x, to_y, to_z, zero fill
  input  wire logic [nid_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind
  input  wire logic                               in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // root_or_length, zero fill
  output logic      [nid_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // capped
  output logic                                    out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready
);

  localparam int PW    = nid_pkg::POINT_W;
  localparam int DW    = PW + 1;
  localparam int AXW   = DW - LENGTH_SHIFT;
  localparam int SQW   = 2 * AXW;
  localparam int SUMW  = SQW + 2;
  localparam int XW    = (SUMW > nid_pkg::RADICAND_W) ? SUMW : nid_pkg::RADICAND_W;
  localparam int DCW   = $clog2(XW);
  localparam int SCW   = $clog2(MAX_STEPS + 1);
  localparam int SCALEW = XW + 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_SQUARE,
    S_SEED,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t             state_r;
  logic               kind_r;
  logic [PW-1:0]      from_r [3];
  logic [PW-1:0]      to_r   [3];
  logic [1:0]         axis_r;
  logic [AXW-1:0]     mag_r;
  logic [XW-1:0]      x_r;
  logic [XW-1:0]      g_r;
  logic [XW-1:0]      rem_r;
  logic [XW-1:0]      quo_r;
  logic [DCW-1:0]     dcnt_r;
  logic [SCW-1:0]     step_r;
  logic [XW-1:0]      root_r;
  logic               capped_r;
  logic [nid_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic               out_user_r;
  logic               out_valid_r;

  // axis difference, floor shift and magnitude
  logic signed [DW-1:0] ax_diff;
  logic signed [DW-1:0] ax_shift;
  logic        [DW-1:0] ax_abs;
  logic        [SQW-1:0] ax_sq;

  always_comb begin
    ax_diff  = $signed({to_r[axis_r][PW-1], to_r[axis_r]})
             - $signed({from_r[axis_r][PW-1], from_r[axis_r]});
    ax_shift = ax_diff >>> LENGTH_SHIFT;
    ax_abs   = ax_shift[DW-1] ? DW'(-ax_shift) : DW'(ax_shift);
    ax_sq    = mag_r * mag_r;
  end

  // one restoring divider step
  logic [XW:0]   rem_sh;
  logic          rem_ge;
  logic [XW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[XW-1]};
    rem_ge  = rem_sh >= {1'b0, g_r};
    rem_sub = rem_sh - {1'b0, g_r};
  end

  // newton update and convergence test
  logic [XW:0]   nx_sum;
  logic [XW-1:0] nx;
  logic [XW-1:0] nx_gap;

  always_comb begin
    nx_sum = {1'b0, g_r} + {1'b0, quo_r};
    nx     = nx_sum[XW:1];
    nx_gap = (g_r > nx) ? (g_r - nx) : (nx - g_r);
  end

  // scaled result
  logic [SCALEW-1:0] scaled;

  always_comb begin
    if (kind_r == nid_pkg::KIND_DISTANCE) begin
      scaled = SCALEW'(root_r) << LENGTH_SHIFT;
    end else begin
      scaled = SCALEW'(root_r);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: filled from the finishing state, emptied on handshake
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r    <= in_tuser;
            from_r[0] <= in_tdata[51:31];
            from_r[1] <= in_tdata[72:52];
            from_r[2] <= in_tdata[93:73];
            to_r[0]   <= in_tdata[114:94];
            to_r[1]   <= in_tdata[135:115];
            to_r[2]   <= in_tdata[156:136];
            axis_r    <= 2'd0;
            if (in_tuser == nid_pkg::KIND_DISTANCE) begin
              x_r     <= '0;
              state_r <= S_AXIS;
            end else begin
              x_r     <= XW'(in_tdata[nid_pkg::RADICAND_W-1:0]);
              state_r <= S_SEED;
            end
          end
        end
        S_AXIS: begin
          mag_r   <= AXW'(ax_abs);
          state_r <= S_SQUARE;
        end
        S_SQUARE: begin
          x_r <= x_r + XW'(ax_sq);
          if (axis_r == 2'd2) begin
            state_r <= S_SEED;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_AXIS;
          end
        end
        S_SEED: begin
          if (x_r < XW'(nid_pkg::BOUND_SMALL)) begin
            g_r <= XW'(nid_pkg::GUESS_SMALL);
          end else if (x_r < XW'(nid_pkg::BOUND_MID)) begin
            g_r <= XW'(nid_pkg::GUESS_MID);
          end else begin
            g_r <= XW'(nid_pkg::GUESS_LARGE);
          end
          step_r  <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (step_r == SCW'(MAX_STEPS)) begin
            root_r   <= g_r;
            capped_r <= 1'b1;
            state_r  <= S_DONE;
          end else if (x_r == '0 || g_r == '0) begin
            root_r   <= '0;
            capped_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            rem_r   <= '0;
            quo_r   <= x_r;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_ge ? rem_sub[XW-1:0] : rem_sh[XW-1:0];
          quo_r  <= {quo_r[XW-2:0], rem_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCW'(XW - 1)) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (nx_gap < XW'(nid_pkg::CONVERGE_GAP)) begin
            root_r   <= nx;
            capped_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            g_r     <= nx;
            step_r  <= step_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_DONE: begin
          // hand over once the output register is free or being emptied
          if (!out_valid_r || out_tready) begin
            out_data_r  <= nid_pkg::OUT_TDATA_W'(scaled[nid_pkg::ROOT_W-1:0]);
            out_user_r  <= capped_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // the step count never passes the limit
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= SCW'(MAX_STEPS))
    else $error("newton step count beyond limit");

  // the divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> g_r != '0)
    else $error("divider running with zero guess");

  // a new result only appears from the finishing state
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside finishing state");

  // an accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready after accepting an item");

endmodule

`default_nettype wire

>>> verif/nid_checker.sv
// checker for the newton square root and distance block: predicts each result and compares
module nid_checker #(
  parameter int LENGTH_SHIFT = 6,
  parameter int MAX_STEPS    = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [nid_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [nid_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             out_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  output int                               fail_count,
  output int                               pending,
  output int                               checked,
  output int                               dist_seen,
  output int                               capped_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROOT_W      = nid_pkg::ROOT_W;
  localparam int POINT_W     = nid_pkg::POINT_W;
  localparam int RADICAND_W  = nid_pkg::RADICAND_W;
  localparam int IN_TDATA_W  = nid_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = nid_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              capped;
  } root_result_t;

  root_result_t roots_due[$];
  int fails = 0;
  int n_checked = 0;
  int n_dist = 0;
  int n_capped = 0;

  // newton iteration from a magnitude-picked seed, with the step limit
  function automatic longint unsigned newton_isqrt(input longint unsigned x,
                                                   output bit capped);
    longint unsigned g, nx, gap;
    int steps;
    if (x < nid_pkg::BOUND_SMALL) g = nid_pkg::GUESS_SMALL;
    else if (x < nid_pkg::BOUND_MID) g = nid_pkg::GUESS_MID;
    else g = nid_pkg::GUESS_LARGE;
    capped = 1'b0;
    for (steps = 1; steps <= MAX_STEPS; steps++) begin
      if (x == 0 || g == 0) return 0;
      nx  = (g + x / g) / 2;
      gap = (g > nx) ? g - nx : nx - g;
      if (gap < nid_pkg::CONVERGE_GAP) return nx;
      g = nx;
    end
    capped = 1'b1;
    return g;
  endfunction

  // expected result of one accepted item
  function automatic root_result_t item_root(input logic kind,
                                             input logic [IN_TDATA_W-1:0] d);
    longint unsigned sum, value;
    longint signed diff;
    logic signed [POINT_W-1:0] p_from, p_to;
    bit cap;
    int axis;
    root_result_t r;
    if (kind == nid_pkg::KIND_DISTANCE) begin
      sum = 0;
      for (axis = 0; axis < 3; axis++) begin
        p_from = d[RADICAND_W + POINT_W*axis +: POINT_W];
        p_to   = d[RADICAND_W + POINT_W*(axis+3) +: POINT_W];
        // arithmetic shift of a signed value rounds toward minus infinity
        diff = (longint'(p_to) - longint'(p_from)) >>> LENGTH_SHIFT;
        if (diff < 0) diff = -diff;
        sum += longint'(diff * diff);
      end
      value = newton_isqrt(sum, cap) << LENGTH_SHIFT;
    end else begin
      value = newton_isqrt({33'd0, d[RADICAND_W-1:0]}, cap);
    end
    r.root   = value[ROOT_W-1:0];
    r.capped = cap;
    return r;
  endfunction

  // watch both channels at every edge
  always @(posedge clk) begin
    root_result_t due;
    if (!rst_n) begin
      fail_count  <= 0;
      pending     <= 0;
      checked     <= 0;
      dist_seen   <= 0;
      capped_seen <= 0;
    end else begin
      // result item against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (roots_due.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, %s %0d capped %0b",
                   $time, "actual root", out_tdata[ROOT_W-1:0], out_tuser);
          fails++;
        end else begin
          due = roots_due.pop_front();
          n_checked++;
          if (due.capped) n_capped++;
          if (out_tdata[ROOT_W-1:0] !== due.root) begin
            $display("%0t: root mismatch: expected %0d, actual %0d",
                     $time, due.root, out_tdata[ROOT_W-1:0]);
            fails++;
          end
          if (out_tuser !== due.capped) begin
            $display("%0t: capped mismatch: expected %0b, actual %0b",
                     $time, due.capped, out_tuser);
            fails++;
          end
          if (out_tdata[OUT_TDATA_W-1:ROOT_W] !== '0) begin
            $display("%0t: tdata fill mismatch: expected 0, actual %0h",
                     $time, out_tdata[OUT_TDATA_W-1:ROOT_W]);
            fails++;
          end
        end
      end
      // input item gives one expectation
      if (in_tvalid && in_tready) begin
        roots_due.push_back(item_root(in_tuser, in_tdata));
        if (in_tuser == nid_pkg::KIND_DISTANCE) n_dist++;
      end
      fail_count  <= fails;
      pending     <= roots_due.size();
      checked     <= n_checked;
      dist_seen   <= n_dist;
      capped_seen <= n_capped;
    end
  end

endmodule

>>> verif/tb_top.sv
// top of the testbench for the newton square root and distance block: stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINT_W      = nid_pkg::POINT_W;
  localparam int RADICAND_W   = nid_pkg::RADICAND_W;
  localparam int IN_TDATA_W   = nid_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = nid_pkg::OUT_TDATA_W;
  localparam int BOUND_SMALL  = nid_pkg::BOUND_SMALL;
  localparam int BOUND_MID    = nid_pkg::BOUND_MID;

  localparam int LENGTH_SHIFT  = 6;
  localparam int MAX_STEPS     = 10;
  localparam int RANDOM_ITEMS  = 1130;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 3000;
  localparam int PAUSE_AT      = 650;
  localparam int CALM_FIRST    = 800;
  localparam int CALM_LAST     = 950;
  localparam int SETTLE_CYCLES = 500;
  localparam int IDLE_PCT      = 34;

  localparam logic [POINT_W-1:0] POINT_MIN = 21'h100000;
  localparam logic [POINT_W-1:0] POINT_MAX = 21'h0FFFFF;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = nid_pkg::KIND_ROOT;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int fail_count, pending, checked, dist_seen, capped_seen;

  newton_isqrt_distance #(
    .LENGTH_SHIFT (LENGTH_SHIFT),
    .MAX_STEPS    (MAX_STEPS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  nid_checker #(
    .LENGTH_SHIFT (LENGTH_SHIFT),
    .MAX_STEPS    (MAX_STEPS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .dist_seen   (dist_seen),
    .capped_seen (capped_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(
      input logic [RADICAND_W-1:0] rad,
      input logic [POINT_W-1:0] fx, fy, fz, tx, ty, tz);
    return {3'b000, tz, ty, tx, fz, fy, fx, rad};
  endfunction

  function automatic logic [POINT_W-1:0] any_point();
    return POINT_W'($urandom);
  endfunction

  function automatic logic [POINT_W-1:0] edge_point();
    case ($urandom_range(0, 3))
      0: return POINT_MIN;
      1: return POINT_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // radicands spread over the seed bounds, squares and the full range
  function automatic logic [RADICAND_W-1:0] pick_radicand();
    longint unsigned s;
    case ($urandom_range(0, 5))
      0: return RADICAND_W'($urandom);
      1: return RADICAND_W'($urandom_range(0, 7000));
      2: return RADICAND_W'($urandom_range(BOUND_SMALL - 40, BOUND_SMALL + 40));
      3: return RADICAND_W'($urandom_range(BOUND_MID - 400, BOUND_MID + 400));
      4: begin
        s = $urandom_range(0, 46340);
        return RADICAND_W'(s * s + $urandom_range(0, 2) - 1);
      end
      default: return RADICAND_W'($urandom_range(0, 3000000));
    endcase
  endfunction

  // offer one item, with random gaps before it, and wait until taken
  task automatic send_item(input logic kind, input logic [IN_TDATA_W-1:0] data);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_root(input logic [RADICAND_W-1:0] rad);
    send_item(nid_pkg::KIND_ROOT, pack_item(rad, any_point(), any_point(), any_point(),
                                            any_point(), any_point(), any_point()));
  endtask

  task automatic send_distance(input logic [POINT_W-1:0] fx, fy, fz, tx, ty, tz);
    send_item(nid_pkg::KIND_DISTANCE,
              pack_item(RADICAND_W'($urandom), fx, fy, fz, tx, ty, tz));
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stimulus and verdict
  initial begin
    logic [POINT_W-1:0] p [6];
    int n, ax;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // roots: zero, tiny values, both seed bounds, top of range, squares
    send_root(31'd0);
    send_root(31'd1);
    send_root(31'd2);
    send_root(31'd3);
    send_root(31'd4);
    send_root(RADICAND_W'(BOUND_SMALL - 1));
    send_root(RADICAND_W'(BOUND_SMALL));
    send_root(RADICAND_W'(BOUND_MID - 1));
    send_root(RADICAND_W'(BOUND_MID));
    send_root(31'd999999);
    send_root(31'd2147395600);
    send_root(31'h7FFFFFFF);

    // distances: same point, floor rounding near the shift, full extents
    send_distance('0, '0, '0, '0, '0, '0);
    p[0] = any_point();
    p[1] = any_point();
    p[2] = any_point();
    send_distance(p[0], p[1], p[2], p[0], p[1], p[2]);
    send_distance('0, '0, '0, 21'd63, '0, '0);
    send_distance('0, '0, '0, 21'h1FFFFF, '0, '0);
    send_distance('0, '0, '0, 21'd64, 21'h1FFFC0, 21'h1FFFBF);
    send_distance(POINT_MIN, '0, '0, POINT_MAX, '0, '0);
    send_distance(POINT_MIN, POINT_MIN, POINT_MIN, POINT_MAX, POINT_MAX, POINT_MAX);
    send_distance(POINT_MAX, POINT_MAX, POINT_MAX, POINT_MIN, POINT_MIN, POINT_MIN);

    // random items with a hold-off, a drain pause and a stretch without gaps
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 1) == 0) begin
        send_root(pick_radicand());
      end else begin
        for (ax = 0; ax < 3; ax++) p[ax] = any_point();
        case ($urandom_range(0, 3))
          0: for (ax = 3; ax < 6; ax++) p[ax] = any_point();
          1: for (ax = 3; ax < 6; ax++)
               p[ax] = p[ax-3] + POINT_W'($urandom_range(0, 400)) - 21'd200;
          2: for (ax = 0; ax < 6; ax++) p[ax] = edge_point();
          default: begin
            for (ax = 3; ax < 6; ax++) p[ax] = p[ax-3];
            ax = $urandom_range(0, 2);
            p[ax+3] = p[ax] + POINT_W'($urandom_range(0, 255)) - 21'd128;
          end
        endcase
        send_distance(p[0], p[1], p[2], p[3], p[4], p[5]);
      end
    end
    calm = 1'b0;

    // drain and let the block settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d distances), %0d results checked, %0d capped",
             items_sent, dist_seen, checked, capped_seen);
    $display("Stalls: one %0d-cycle receiver hold-off, one drain pause, %0d items without gaps",
             HOLD_CYCLES, CALM_LAST - CALM_FIRST);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nid_pkg.sv
rtl/newton_isqrt_distance.sv
verif/nid_checker.sv
verif/tb_top.sv
